// ----- hdl/ptc_pkg.sv -----
// Package for the packet capture trigger controller: word types, phase and
// request codes, configuration register indexes and the phase encoding helper.
// Used by every module of the block; depends on nothing else.
package ptc_pkg;

    localparam int TIME_W = 64;

    localparam logic [1:0] REQ_START  = 2'd0;
    localparam logic [1:0] REQ_STOP   = 2'd1;
    localparam logic [1:0] REQ_PACKET = 2'd2;

    localparam logic [1:0] CODE_STOPPED = 2'd0;
    localparam logic [1:0] CODE_ARMED   = 2'd1;
    localparam logic [1:0] CODE_STARTED = 2'd2;

    localparam logic [1:0] CFG_START_TRIG_EN = 2'd0;
    localparam logic [1:0] CFG_STOP_TRIG_EN  = 2'd1;
    localparam logic [1:0] CFG_FILTER_EN     = 2'd2;
    localparam logic [1:0] CFG_DURATION      = 2'd3;

    typedef enum logic [2:0] {
        PH_STOPPED = 3'b001,
        PH_ARMED   = 3'b010,
        PH_STARTED = 3'b100
    } phase_t;

    typedef struct packed {
        logic [1:0]        req_type;
        logic [TIME_W-1:0] now_time;
        logic [TIME_W-1:0] packet_time;
        logic              start_match;
        logic              stop_match;
        logic              filter_pass;
        logic              last_in_burst;
        logic              store_full;
    } ptc_in_t;

    typedef struct packed {
        logic              capture_write;
        logic [1:0]        capture_phase;
        logic              phase_changed;
        logic [TIME_W-1:0] event_time;
    } ptc_out_t;

    typedef struct packed {
        logic              start_trigger_enable;
        logic              stop_trigger_enable;
        logic              filter_enable;
        logic [TIME_W-1:0] capture_duration;
    } ptc_cfg_t;

    typedef struct packed {
        phase_t            phase;
        logic [TIME_W-1:0] deadline;
        logic              deadline_valid;
        logic [TIME_W-1:0] last_event_time;
    } ptc_state_t;

    function automatic logic [1:0] phase_code(input phase_t ph);
        logic [1:0] code;
        unique case (ph)
            PH_STOPPED: code = CODE_STOPPED;
            PH_ARMED:   code = CODE_ARMED;
            PH_STARTED: code = CODE_STARTED;
            default:    code = CODE_STOPPED;
        endcase
        return code;
    endfunction

endpackage

// ----- hdl/ptc_cfg_regs.sv -----
// Configuration register file of the packet capture trigger controller.
// Depends on ptc_pkg for the register indexes and the configuration struct.
module ptc_cfg_regs import ptc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [TIME_W-1:0] cfg_data,
    output ptc_cfg_t          cfg
);

    ptc_cfg_t cfg_reg;
    ptc_cfg_t cfg_next;

    assign cfg_ready = 1'b1;
    assign cfg       = cfg_reg;

    always_comb begin
        cfg_next = cfg_reg;
        if (cfg_valid) begin
            unique case (cfg_index)
                CFG_START_TRIG_EN: cfg_next.start_trigger_enable = cfg_data[0];
                CFG_STOP_TRIG_EN:  cfg_next.stop_trigger_enable  = cfg_data[0];
                CFG_FILTER_EN:     cfg_next.filter_enable        = cfg_data[0];
                CFG_DURATION:      cfg_next.capture_duration     = cfg_data;
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg <= '0;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ----- hdl/ptc_in_reg.sv -----
// Input register stage of the packet capture trigger controller.
// Holds one accepted word until the step logic moves it on; uses ptc_pkg.
module ptc_in_reg import ptc_pkg::*; (
    input  logic    aclk,
    input  logic    aresetn,
    input  logic    s_valid,
    output logic    s_ready,
    input  ptc_in_t s_data,
    input  logic    advance,
    output logic    hold_valid,
    output ptc_in_t hold_data
);

    logic    valid_reg;
    logic    valid_next;
    ptc_in_t data_reg;

    assign s_ready    = !valid_reg || advance;
    assign valid_next = s_ready ? s_valid : valid_reg;
    assign hold_valid = valid_reg;
    assign hold_data  = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            data_reg <= s_data;
        end
    end

endmodule

// ----- hdl/ptc_step.sv -----
// Single-pass step logic of the packet capture trigger controller: next phase,
// deadline, event time and write decision for one word. Uses ptc_pkg.
module ptc_step import ptc_pkg::*; (
    input  ptc_cfg_t   cfg,
    input  ptc_state_t state,
    input  ptc_in_t    word,
    output ptc_state_t state_next,
    output ptc_out_t   result
);

    logic [TIME_W:0]   sum;
    logic [TIME_W-1:0] start_deadline;
    logic              start_deadline_valid;

    assign sum                  = {1'b0, word.now_time} + {1'b0, cfg.capture_duration};
    assign start_deadline_valid = cfg.capture_duration != '0;
    assign start_deadline       = !start_deadline_valid ? '0 :
                                  (sum[TIME_W] ? '1 : sum[TIME_W-1:0]);

    always_comb begin
        ptc_state_t nst;
        phase_t     target;
        logic       changed;
        logic       write;
        logic       stopping;
        nst      = state;
        changed  = 1'b0;
        write    = 1'b0;
        stopping = 1'b0;
        target   = cfg.start_trigger_enable ? PH_ARMED : PH_STARTED;
        unique case (word.req_type)
            REQ_START: begin
                if (target != state.phase) begin
                    changed   = 1'b1;
                    nst.phase = target;
                    if (target == PH_STARTED) begin
                        nst.last_event_time = word.now_time;
                        nst.deadline        = start_deadline;
                        nst.deadline_valid  = start_deadline_valid;
                    end
                end
            end
            REQ_STOP: begin
                if (state.phase != PH_STOPPED) begin
                    changed             = 1'b1;
                    nst.phase           = PH_STOPPED;
                    nst.last_event_time = word.now_time;
                end
            end
            REQ_PACKET: begin
                if (state.phase == PH_ARMED && word.start_match) begin
                    changed             = 1'b1;
                    nst.phase           = PH_STARTED;
                    nst.last_event_time = word.now_time;
                    nst.deadline        = start_deadline;
                    nst.deadline_valid  = start_deadline_valid;
                end
                if (nst.phase == PH_STARTED) begin
                    stopping = (cfg.stop_trigger_enable && word.stop_match) ||
                               (nst.deadline_valid && (word.packet_time > nst.deadline));
                    write    = cfg.filter_enable ? word.filter_pass : 1'b1;
                    if (stopping || (word.last_in_burst && word.store_full)) begin
                        changed             = 1'b1;
                        nst.phase           = PH_STOPPED;
                        nst.last_event_time = word.now_time;
                    end
                end
            end
            default: begin
                nst = state;
            end
        endcase
        state_next           = nst;
        result.capture_write = write;
        result.capture_phase = phase_code(nst.phase);
        result.phase_changed = changed;
        result.event_time    = nst.last_event_time;
    end

endmodule

// ----- hdl/packet_capture_trigger_control.sv -----
// Packet capture start/stop trigger controller: one result word for every
// command or packet word, with stopped, armed and started phases.
// Depends on ptc_pkg, ptc_cfg_regs, ptc_in_reg and ptc_step.
//
// Every accepted word produces exactly one result word, held first in the
// input register and then in the result register. A new word is accepted in
// every cycle while the output side does not stall, and a waiting result does
// not block the word behind it, which is held in the input register. The
// phase, deadline and event time are updated by the single-pass step logic
// between those two registers, whose 64-bit saturating deadline add and
// timestamp compare set the clock period. Configuration writes are taken in
// every cycle and must only be issued while no word is in flight.
module packet_capture_trigger_control import ptc_pkg::*; (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  ptc_in_t           s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output ptc_out_t          m_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  logic [1:0]        cfg_index,
    input  logic [TIME_W-1:0] cfg_data
);

    ptc_cfg_t   cfg;
    logic       hold_valid;
    ptc_in_t    hold_data;
    logic       advance;
    ptc_state_t state_reg;
    ptc_state_t state_next;
    ptc_out_t   result;
    logic       m_valid_reg;
    logic       m_valid_next;
    ptc_out_t   m_data_reg;

    ptc_cfg_regs u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    ptc_in_reg u_in (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_data     (s_data),
        .advance    (advance),
        .hold_valid (hold_valid),
        .hold_data  (hold_data)
    );

    ptc_step u_step (
        .cfg        (cfg),
        .state      (state_reg),
        .word       (hold_data),
        .state_next (state_next),
        .result     (result)
    );

    assign advance      = hold_valid && (!m_valid_reg || m_ready);
    assign m_valid_next = advance ? 1'b1 : (m_valid_reg && !m_ready);
    assign m_valid      = m_valid_reg;
    assign m_data       = m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
            state_reg   <= '{phase: PH_STOPPED, deadline: '0, deadline_valid: 1'b0,
                             last_event_time: '0};
        end else begin
            m_valid_reg <= m_valid_next;
            if (advance) begin
                state_reg <= state_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            m_data_reg <= result;
        end
    end

endmodule

// ----- hdl/ptc_checker.sv -----
// Port-level checker for the packet capture trigger controller, bound to the
// top level at the end of this file. Depends on ptc_pkg.
module ptc_checker import ptc_pkg::*; (
    input logic     aclk,
    input logic     aresetn,
    input logic     m_valid,
    input logic     m_ready,
    input ptc_out_t m_data
);

    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("Result word changed or dropped while stalled.");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("Result valid after reset.");

    a_phase_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_data.capture_phase == CODE_STOPPED ||
                    m_data.capture_phase == CODE_ARMED ||
                    m_data.capture_phase == CODE_STARTED)
        else $error("Result carries an unused phase code.");

    a_write_not_armed: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.capture_write |-> m_data.capture_phase != CODE_ARMED)
        else $error("Capture write reported with the controller armed.");

endmodule

bind packet_capture_trigger_control ptc_checker u_ptc_checker (.*);
